>>> hw/rtl/b2d_pkg.sv
package b2d_pkg;

  // field widths
  localparam int VALUE_W  = 64;
  localparam int MINLEN_W = 7;
  localparam int TZ_W     = 6;
  localparam int CHAR_W   = 6;

  // longest text that is emitted
  localparam int MAX_CHARS = 64;

  // decimal digits of a 64-bit value and their packed bcd width
  localparam int DIGITS_MAX = 20;
  localparam int BCD_W      = 4 * DIGITS_MAX;
  localparam int NDIG_W     = $clog2(DIGITS_MAX + 1);

  // bit counter for the conversion pass
  localparam int BIT_CNT_W = $clog2(VALUE_W);

  // text length before clipping, and the emitted count
  localparam int LEN_W  = 8;
  localparam int EMIT_W = $clog2(MAX_CHARS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_EMIT
  } b2d_state_e;

  // commands to the bcd unit
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift4;
  } bcd_ctrl_t;

  // commands to the emitter
  typedef struct packed {
    logic capture;
    logic start;
  } emit_ctrl_t;

  // status from the emitter
  typedef struct packed {
    logic busy;
    logic pop;
  } emit_stat_t;

endpackage

>>> hw/rtl/b2d_in_if.sv
interface b2d_in_if;
  import b2d_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [MINLEN_W-1:0] min_length;
  logic [TZ_W-1:0]     trailing_zeros;

  modport source (output valid, value, min_length, trailing_zeros, input ready);
  modport sink   (input valid, value, min_length, trailing_zeros, output ready);
endinterface

>>> hw/rtl/b2d_out_if.sv
interface b2d_out_if;
  import b2d_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last;

  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface

>>> hw/rtl/b2d_bcd_unit.sv
module b2d_bcd_unit
  import b2d_pkg::*;
(
  input  logic               clk_i,
  input  bcd_ctrl_t          ctrl_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic [3:0]         top_digit_o,
  output logic [NDIG_W-1:0]  ndig_o
);

  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [BCD_W-1:0]   bcd_adj;
  logic [NDIG_W-1:0]  ndig_q, ndig_d;

  // add 3 to every digit of 5 or more
  always_comb begin
    for (int i = 0; i < DIGITS_MAX; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // shared shift unit: a load, one binary bit in, or one digit out at the top
  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    ndig_d = ndig_q;
    if (ctrl_i.load) begin
      bin_d  = value_i;
      bcd_d  = '0;
      ndig_d = NDIG_W'(DIGITS_MAX);
    end else if (ctrl_i.dabble) begin
      bin_d = {bin_q[VALUE_W-2:0], 1'b0};
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
    end else if (ctrl_i.shift4) begin
      bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
      ndig_d = ndig_q - NDIG_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    ndig_q <= ndig_d;
  end

  assign top_digit_o = bcd_q[BCD_W-1 -: 4];
  assign ndig_o      = ndig_q;

endmodule

>>> hw/rtl/b2d_emit.sv
module b2d_emit
  import b2d_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  emit_ctrl_t          ctrl_i,
  input  logic [MINLEN_W-1:0] min_length_i,
  input  logic [TZ_W-1:0]     trailing_zeros_i,
  input  logic [3:0]          top_digit_i,
  input  logic [NDIG_W-1:0]   ndig_i,
  output emit_stat_t          stat_o,
  b2d_out_if.source           out_o
);

  logic [MINLEN_W-1:0] min_len_q;
  logic [TZ_W-1:0]     tz_q;
  logic [LEN_W-1:0]    natural_len, total_len, pad_len;
  logic [EMIT_W-1:0]   emit_len;
  logic                busy_q, busy_d;
  logic [LEN_W-1:0]    pad_q, pad_d;
  logic [NDIG_W-1:0]   dig_q, dig_d;
  logic [EMIT_W-1:0]   rem_q, rem_d;
  logic                valid_q, valid_d;
  logic [CHAR_W-1:0]   char_q, char_d;
  logic                last_q, last_d;
  logic                adv;
  logic [CHAR_W-1:0]   next_char;
  logic                in_digits;

  // item parameters held for the emission phase
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      min_len_q <= min_length_i;
      tz_q      <= trailing_zeros_i;
    end
  end

  // text length, leading padding and clipped count
  always_comb begin
    natural_len = LEN_W'(ndig_i) + LEN_W'(tz_q);
    if (natural_len < LEN_W'(min_len_q)) begin
      total_len = LEN_W'(min_len_q);
    end else begin
      total_len = natural_len;
    end
    pad_len = total_len - natural_len;
    if (total_len > LEN_W'(MAX_CHARS)) begin
      emit_len = EMIT_W'(MAX_CHARS);
    end else begin
      emit_len = total_len[EMIT_W-1:0];
    end
  end

  // next character: padding, then digits from the top, then trailing zeros
  assign adv       = busy_q && (!valid_q || out_o.ready);
  assign in_digits = (pad_q == '0) && (dig_q != '0);
  assign next_char = in_digits ? (ASCII_ZERO + CHAR_W'(top_digit_i)) : ASCII_ZERO;

  always_comb begin
    busy_d  = busy_q;
    pad_d   = pad_q;
    dig_d   = dig_q;
    rem_d   = rem_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      pad_d  = pad_len;
      dig_d  = ndig_i;
      rem_d  = emit_len;
      // the previous item's last character may leave in this cycle
      if (out_o.ready) begin
        valid_d = 1'b0;
      end
    end else if (adv) begin
      valid_d = 1'b1;
      char_d  = next_char;
      last_d  = (rem_q == EMIT_W'(1));
      busy_d  = (rem_q != EMIT_W'(1));
      rem_d   = rem_q - EMIT_W'(1);
      if (pad_q != '0) begin
        pad_d = pad_q - LEN_W'(1);
      end else if (dig_q != '0) begin
        dig_d = dig_q - NDIG_W'(1);
      end
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      pad_q   <= '0;
      dig_q   <= '0;
      rem_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
      pad_q   <= pad_d;
      dig_q   <= dig_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign stat_o.busy    = busy_q;
  assign stat_o.pop     = adv && in_digits;
  assign out_o.valid    = valid_q;
  assign out_o.char_out = char_q;
  assign out_o.last     = last_q;

endmodule

>>> hw/rtl/binary_to_decimal_ascii_padded.sv
// Converts an unsigned 64-bit value to decimal ASCII text, one character per
// output item, most significant first, with last set on the final character.
// Trailing '0' characters follow the digits and leading '0' characters pad the
// text up to min_length; the text is clipped to 64 characters. An item passes
// through these steps: the block takes it while idle, one shared
// shift-and-add-3 unit takes in the 64 binary bits one at a time, leading zero
// digits are shifted out while keeping at least one digit, the emitter is
// started, the emitter sends the characters one by one as the output takes
// them, and the block returns to idle. Input ready is high only while the block
// is idle; the last character may still wait in the output register while the
// next item is taken.
module binary_to_decimal_ascii_padded
  import b2d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  b2d_in_if.sink    in_i,
  b2d_out_if.source out_o
);

  b2d_state_e           state_q, state_d;
  logic [BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 accept;
  logic                 norm_more;
  logic [3:0]           top_digit;
  logic [NDIG_W-1:0]    ndig;
  bcd_ctrl_t            bcd_ctrl;
  emit_ctrl_t           emit_ctrl;
  emit_stat_t           emit_stat;

  assign accept    = in_i.valid && in_i.ready;
  assign norm_more = (ndig > NDIG_W'(1)) && (top_digit == 4'd0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_CONV;
      ST_CONV: if (cnt_q == BIT_CNT_W'(VALUE_W - 1)) state_d = ST_NORM;
      ST_NORM: if (!norm_more) state_d = ST_EMIT;
      ST_EMIT: if (!emit_stat.busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready       = 1'b0;
    bcd_ctrl         = '0;
    emit_ctrl        = '0;
    cnt_d            = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_i.ready        = 1'b1;
        bcd_ctrl.load     = accept;
        emit_ctrl.capture = accept;
        cnt_d             = '0;
      end
      ST_CONV: begin
        bcd_ctrl.dabble = 1'b1;
        cnt_d           = cnt_q + BIT_CNT_W'(1);
      end
      ST_NORM: begin
        bcd_ctrl.shift4 = norm_more;
        emit_ctrl.start = !norm_more;
      end
      ST_EMIT: begin
        bcd_ctrl.shift4 = emit_stat.pop;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // shared shift-and-add-3 unit
  b2d_bcd_unit u_bcd (
    .clk_i       (clk_i),
    .ctrl_i      (bcd_ctrl),
    .value_i     (in_i.value),
    .top_digit_o (top_digit),
    .ndig_o      (ndig)
  );

  // character emitter with output register
  b2d_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (emit_ctrl),
    .min_length_i     (in_i.min_length),
    .trailing_zeros_i (in_i.trailing_zeros),
    .top_digit_i      (top_digit),
    .ndig_i           (ndig),
    .stat_o           (emit_stat),
    .out_o            (out_o)
  );

endmodule

>>> sim/testbench.sv
module testbench;
  import b2d_pkg::*;

  // one expected character of the decimal text
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // one row of the directed part; an empty text means use the predictor
  typedef struct {
    logic [VALUE_W-1:0]  value;
    logic [MINLEN_W-1:0] min_len;
    logic [TZ_W-1:0]     tz;
    string               text;
  } number_row_t;

  localparam int NUM_ROWS     = 23;
  localparam int RANDOM_ITEMS = 97;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 150;

  localparam logic [VALUE_W-1:0] ALL_ONES = '1;

  logic clk_i;
  logic rst_ni;

  b2d_in_if  in_ch ();
  b2d_out_if out_ch ();

  binary_to_decimal_ascii_padded dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  text_char_t pending_chars[$];
  int         mismatches = 0;
  bit         no_idle = 1'b0;
  int         out_stall;
  int         idle_cycles = 0;

  // clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // expected text of one item, character by character
  function automatic void predict_text(input logic [VALUE_W-1:0] value,
                                       input logic [MINLEN_W-1:0] min_len,
                                       input logic [TZ_W-1:0] tz);
    logic [VALUE_W-1:0] rest;
    logic [3:0]         dig[DIGITS_MAX];
    int                 ndig;
    int                 total;
    int                 pad;
    int                 emit;
    text_char_t         c;
    ndig = 0;
    rest = value;
    if (rest == '0) begin
      dig[0] = 4'd0;
      ndig = 1;
    end else begin
      while (rest != '0) begin
        dig[ndig] = 4'(rest % 64'd10);
        rest = rest / 64'd10;
        ndig++;
      end
    end
    total = ndig + int'(tz);
    if (total < int'(min_len)) begin
      total = int'(min_len);
    end
    pad  = total - ndig - int'(tz);
    emit = (total > MAX_CHARS) ? MAX_CHARS : total;
    for (int k = 0; k < emit; k++) begin
      c.ch = ASCII_ZERO;
      // digit positions sit between the padding and the trailing zeros
      if (k >= pad && k < pad + ndig) begin
        c.ch = ASCII_ZERO + CHAR_W'(dig[ndig - 1 - (k - pad)]);
      end
      c.last = (k == emit - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // expected text typed in as a string
  function automatic void push_text(input string text);
    text_char_t c;
    for (int k = 0; k < text.len(); k++) begin
      c.ch   = CHAR_W'(text[k]);
      c.last = (k == text.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // offer one item after a random gap and record its text once taken
  task automatic send_number(input logic [VALUE_W-1:0] value,
                             input logic [MINLEN_W-1:0] min_len,
                             input logic [TZ_W-1:0] tz,
                             input string text);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.value          <= value;
    in_ch.min_length     <= min_len;
    in_ch.trailing_zeros <= tz;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (text.len() != 0) begin
      push_text(text);
    end else begin
      predict_text(value, min_len, tz);
    end
  endtask

  // output side: random stalls per item, checked against the oldest expectation
  always @(posedge clk_i) begin
    int nxt;
    text_char_t want;
    if (!rst_ni) begin
      out_stall    <= 0;
      out_ch.ready <= 1'b0;
    end else begin
      nxt = (out_stall > 0) ? out_stall - 1 : 0;
      if (out_ch.valid && out_ch.ready) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected item char=%0d last=%0b", $time,
                   out_ch.char_out, out_ch.last);
          mismatches++;
        end else begin
          want = pending_chars.pop_front();
          if (out_ch.char_out !== want.ch) begin
            $display("%0t: char_out expected %0d actual %0d", $time, want.ch,
                     out_ch.char_out);
            mismatches++;
          end
          if (out_ch.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last,
                     out_ch.last);
            mismatches++;
          end
        end
        nxt = no_idle ? 0 : $urandom_range(0, 3);
      end
      out_stall    <= nxt;
      out_ch.ready <= (nxt == 0);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    number_row_t        rows[NUM_ROWS];
    logic [VALUE_W-1:0] value;
    logic [MINLEN_W-1:0] min_len;
    logic [TZ_W-1:0]    tz;
    int                 nbits;

    rows = '{
      '{64'd0, 7'd0, 6'd0, "0"},
      '{64'd0, 7'd1, 6'd0, "0"},
      '{64'd0, 7'd3, 6'd0, "000"},
      '{64'd0, 7'd0, 6'd1, "00"},
      '{64'd9, 7'd0, 6'd0, "9"},
      '{64'd8, 7'd1, 6'd0, "8"},
      '{64'd10, 7'd0, 6'd0, "10"},
      '{64'd1234567890, 7'd0, 6'd0, "1234567890"},
      '{ALL_ONES, 7'd0, 6'd0, "18446744073709551615"},
      '{ALL_ONES, 7'd25, 6'd0, "0000018446744073709551615"},
      '{64'd10000000000000000000, 7'd0, 6'd0, "10000000000000000000"},
      '{64'd9999999999999999999, 7'd0, 6'd0, "9999999999999999999"},
      '{64'd42, 7'd5, 6'd2, "04200"},
      // min_length below the natural length adds nothing
      '{64'd7, 7'd2, 6'd3, "7000"},
      '{64'd5, 7'd0, 6'd44, ""},
      '{ALL_ONES, 7'd0, 6'd44, ""},
      '{64'd0, 7'd64, 6'd0, ""},
      // text longer than 64 characters is clipped
      '{64'd1, 7'd127, 6'd0, ""},
      '{ALL_ONES, 7'd0, 6'd63, ""},
      '{64'd123, 7'd127, 6'd63, ""},
      '{64'd1, 7'd64, 6'd63, ""},
      '{64'h5555_5555_5555_5555, 7'h2a, 6'h15, ""},
      '{64'haaaa_aaaa_aaaa_aaaa, 7'h55, 6'h2a, ""}
    };

    rst_ni               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.value          = '0;
    in_ch.min_length     = '0;
    in_ch.trailing_zeros = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_number(rows[i].value, rows[i].min_len, rows[i].tz, rows[i].text);
    end

    // hold off until the block has drained
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);

    // random numbers of mixed magnitude
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 16 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 14) == 0) begin
        in_ch.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk_i);
      end
      nbits = $urandom_range(1, VALUE_W);
      value = {$urandom, $urandom};
      if (nbits < VALUE_W) begin
        value = value & ((64'd1 << nbits) - 64'd1);
      end
      if ($urandom_range(0, 11) == 0) begin
        value = '0;
      end
      if ($urandom_range(0, 7) == 0) begin
        min_len = MINLEN_W'($urandom_range(65, 127));
      end else begin
        min_len = MINLEN_W'($urandom_range(0, 64));
      end
      if ($urandom_range(0, 9) == 0) begin
        tz = TZ_W'($urandom_range(45, 63));
      end else if ($urandom_range(0, 3) == 0) begin
        tz = TZ_W'($urandom_range(0, 44));
      end else begin
        tz = TZ_W'($urandom_range(0, 4));
      end
      send_number(value, min_len, tz, "");
    end
    in_ch.valid <= 1'b0;

    // wait for the remaining characters, then a quiet stretch
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/b2d_pkg.sv
hw/rtl/b2d_in_if.sv
hw/rtl/b2d_out_if.sv
hw/rtl/b2d_bcd_unit.sv
hw/rtl/b2d_emit.sv
hw/rtl/binary_to_decimal_ascii_padded.sv
sim/testbench.sv
